/* hw/rtl/apts_pkg.sv */
// Shared constants and the inter-cell carry type of the aging priority task scheduler.
`default_nettype none

package apts_pkg;

    // Table size and derived widths.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PRIO_W = 16;
    localparam int ADDR_W = 64;
    localparam int OP_W   = 2;
    localparam int TGT_W  = 4;
    localparam int SOUT_W = 4;
    localparam int STAT_W = 2;

    // Priority constants in units of 0.05.
    localparam logic [PRIO_W-1:0] PRIO_FREE    = PRIO_W'(20000);
    localparam logic [PRIO_W-1:0] PRIO_MAX     = PRIO_W'(65535);
    localparam logic [PRIO_W-1:0] PRIO_RUN_ADD = PRIO_W'(2);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SCHED   = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_TASK = 2'd2;

    // Token handed from one slot cell to the next during a pass.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [TGT_W-1:0]  target;
        logic [SLOT_W-1:0] running;
        logic              found;
        logic [SLOT_W-1:0] best;
        logic [PRIO_W-1:0] best_prio;
        logic [ADDR_W-1:0] best_res;
    } carry_t;

endpackage

`default_nettype wire

/* hw/rtl/apts_cell.sv */
// One task slot cell: holds a slot's state and updates the passing token.
`default_nettype none

module apts_cell (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire  [apts_pkg::SLOT_W-1:0] cell_idx,
    input  apts_pkg::carry_t            carry_in,
    output apts_pkg::carry_t            carry_out
);
    import apts_pkg::*;

    logic              active_reg, active_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [ADDR_W-1:0] resume_reg, resume_next;
    carry_t            carry_reg, carry_next;

    logic [PRIO_W:0]       run_sum;
    logic [PRIO_W-1:0]     aged;
    logic [ADDR_W-1:0]     res_now;
    logic                  is_target;
    logic                  is_running;

    // Slot match tests, widened so that an out-of-range target matches no cell.
    assign is_target  = ({{SLOT_W{1'b0}}, carry_in.target} == {{TGT_W{1'b0}}, cell_idx});
    assign is_running = (carry_in.running == cell_idx);

    // Cell update for the operation carried by the token.
    always_comb begin
        active_next = active_reg;
        prio_next   = prio_reg;
        resume_next = resume_reg;
        carry_next  = carry_in;
        run_sum     = {1'b0, prio_reg} + {1'b0, PRIO_RUN_ADD};
        aged        = prio_reg;
        res_now     = resume_reg;
        if (carry_in.valid) begin
            case (carry_in.op)
                OP_CREATE: begin
                    if (!carry_in.found && !active_reg) begin
                        active_next     = 1'b1;
                        prio_next       = '0;
                        resume_next     = carry_in.addr;
                        carry_next.found = 1'b1;
                        carry_next.best  = cell_idx;
                    end
                end
                OP_DESTROY: begin
                    if (is_target) begin
                        active_next = 1'b0;
                        prio_next   = PRIO_FREE;
                    end
                end
                OP_SCHED: begin
                    // The running slot ages upward and saves its resume address.
                    if (is_running) begin
                        aged        = run_sum[PRIO_W] ? PRIO_MAX : run_sum[PRIO_W-1:0];
                        res_now     = carry_in.addr;
                        resume_next = carry_in.addr;
                    end
                    // Active slots age downward and compete for the lowest priority.
                    if (active_reg) begin
                        if (aged != '0) begin
                            aged = aged - PRIO_W'(1);
                        end
                        if (!carry_in.found || (aged < carry_in.best_prio)) begin
                            carry_next.found     = 1'b1;
                            carry_next.best      = cell_idx;
                            carry_next.best_prio = aged;
                            carry_next.best_res  = res_now;
                        end
                    end
                    prio_next = aged;
                end
                default: begin
                end
            endcase
        end
    end

    // Slot state and the token register toward the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= (cell_idx == '0);
            prio_reg   <= (cell_idx == '0) ? '0 : PRIO_FREE;
            resume_reg <= '0;
            carry_reg  <= '0;
        end else begin
            active_reg <= active_next;
            prio_reg   <= prio_next;
            resume_reg <= resume_next;
            carry_reg  <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

/* hw/rtl/aging_priority_task_scheduler_unit.sv */
// Top level of the aging priority task scheduler: slot cell chain and result registers.
`default_nettype none

// The block keeps a table of task slots, one cell per slot, each with an active bit,
// a 16-bit aging priority (units of 0.05, saturating at 65535) and a saved 64-bit
// resume address. Opcode 0 runs a schedule tick, 1 creates a task in the lowest free
// slot, 2 frees a slot. Every operation is a token that walks the cell chain one
// cell per clock, then passes the finish register and the output register; the next
// input is taken once the result moves into the output register. The block works on
// one item at a time; a result in the output register waiting on m_ready does not
// block the next item's pass, but a second result then holds in the finish register
// and blocks further input. After reset only slot 0 is active and running, with
// priority 0; all other slots sit at priority 20000.
module aging_priority_task_scheduler_unit (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [apts_pkg::OP_W-1:0]     s_opcode,
    input  wire  [apts_pkg::ADDR_W-1:0]   s_address_in,
    input  wire  [apts_pkg::TGT_W-1:0]    s_target_slot,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [apts_pkg::STAT_W-1:0]   m_status,
    output logic [apts_pkg::SOUT_W-1:0]   m_slot_out,
    output logic                          m_switched,
    output logic [apts_pkg::ADDR_W-1:0]   m_resume_address
);
    import apts_pkg::*;

    carry_t chain [SLOTS+1];

    logic              busy_reg, busy_next;
    logic [SLOT_W-1:0] running_reg, running_next;

    logic              fin_valid_reg, fin_valid_next;
    logic [STAT_W-1:0] fin_status_reg, fin_status_next;
    logic [SOUT_W-1:0] fin_slot_reg, fin_slot_next;
    logic              fin_sw_reg, fin_sw_next;
    logic [ADDR_W-1:0] fin_res_reg, fin_res_next;

    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [SOUT_W-1:0] m_slot_reg;
    logic              m_sw_reg;
    logic [ADDR_W-1:0] m_res_reg;

    logic                     s_xfer;
    logic                     m_load;
    logic                     tail_valid;
    logic [SLOT_W+SOUT_W-1:0] best_wide;
    carry_t                   tail;

    assign s_ready = !busy_reg;
    assign s_xfer  = s_valid && s_ready;
    assign m_load  = fin_valid_reg && (!m_valid_reg || m_ready);

    // Token that enters the first cell on an input transfer.
    always_comb begin
        chain[0]           = '0;
        chain[0].valid     = s_xfer;
        chain[0].op        = s_opcode;
        chain[0].addr      = s_address_in;
        chain[0].target    = s_target_slot;
        chain[0].running   = running_reg;
    end

    // Row of slot cells.
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
        apts_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (SLOT_W'(gi)),
            .carry_in  (chain[gi]),
            .carry_out (chain[gi+1])
        );
    end

    assign tail       = chain[SLOTS];
    assign tail_valid = tail.valid;
    assign best_wide  = {{SOUT_W{1'b0}}, tail.best};

    // Result formation when the token leaves the last cell.
    always_comb begin
        running_next    = running_reg;
        fin_valid_next  = fin_valid_reg;
        fin_status_next = fin_status_reg;
        fin_slot_next   = fin_slot_reg;
        fin_sw_next     = fin_sw_reg;
        fin_res_next    = fin_res_reg;
        busy_next       = busy_reg;
        if (m_load) begin
            fin_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (s_xfer) begin
            busy_next = 1'b1;
        end
        if (tail_valid) begin
            fin_valid_next  = 1'b1;
            fin_status_next = ST_OK;
            fin_slot_next   = '0;
            fin_sw_next     = 1'b0;
            fin_res_next    = '0;
            case (tail.op)
                OP_CREATE: begin
                    if (tail.found) begin
                        fin_slot_next = best_wide[SOUT_W-1:0];
                    end else begin
                        fin_status_next = ST_FULL;
                    end
                end
                OP_DESTROY: begin
                    fin_slot_next = tail.target;
                end
                OP_SCHED: begin
                    if (!tail.found) begin
                        fin_status_next = ST_NO_TASK;
                    end else begin
                        fin_slot_next = best_wide[SOUT_W-1:0];
                        if (tail.best != tail.running) begin
                            fin_sw_next  = 1'b1;
                            fin_res_next = tail.best_res;
                            running_next = tail.best;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state and finish register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            running_reg   <= '0;
            fin_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            running_reg   <= running_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_status_reg <= fin_status_next;
        fin_slot_reg   <= fin_slot_next;
        fin_sw_reg     <= fin_sw_next;
        fin_res_reg    <= fin_res_next;
    end

    // Output register toward the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_status_reg <= fin_status_reg;
            m_slot_reg   <= fin_slot_reg;
            m_sw_reg     <= fin_sw_reg;
            m_res_reg    <= fin_res_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_slot_out       = m_slot_reg;
    assign m_switched       = m_sw_reg;
    assign m_resume_address = m_res_reg;

endmodule

`default_nettype wire

/* tb/tb_aging_priority_task_scheduler_unit.sv */
// Self-checking testbench for the aging priority task scheduler unit.
`timescale 1ns / 100ps

module tb_aging_priority_task_scheduler_unit;

    import apts_pkg::*;

    // Opcode 3 has no meaning in the block and must leave the table alone.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1200;

    // One result transfer, field by field.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SOUT_W-1:0] slot;
        logic              switched;
        logic [ADDR_W-1:0] resume;
    } sched_result_t;

    localparam sched_result_t NO_WANT = '0;

    // One row of the directed plan; rows with chk set carry the result by hand.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [TGT_W-1:0]  tgt;
        logic [4:0]        reps;
        logic              chk;
        sched_result_t     want;
    } plan_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode = '0;
    logic [ADDR_W-1:0]   s_address_in = '0;
    logic [TGT_W-1:0]    s_target_slot = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [SOUT_W-1:0]   m_slot_out;
    logic                m_switched;
    logic [ADDR_W-1:0]   m_resume_address;

    // Shadow copy of the slot table, advanced once per accepted input transfer.
    logic              slot_live [SLOTS];
    logic [PRIO_W-1:0] slot_prio [SLOTS];
    logic [ADDR_W-1:0] slot_saved_pc [SLOTS];
    logic [SLOT_W-1:0] cur_slot;

    sched_result_t outcomes_due [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int switches_seen = 0;
    int full_seen = 0;
    int empty_ticks_seen = 0;

    // The directed plan: first tick, creates up to a full table, destroys,
    // the spare opcode, and re-use of a freed slot.
    plan_row_t plan [13] = '{
        '{OP_SCHED,   64'h0123_4567_89ab_cdef, 4'd0,  5'd1,  1'b1, '{ST_OK, 4'd0, 1'b0, 64'd0}},
        '{OP_CREATE,  64'hffff_ffff_ffff_ffff, 4'hf,  5'd1,  1'b1, '{ST_OK, 4'd1, 1'b0, 64'd0}},
        '{OP_CREATE,  64'h0000_0000_0000_0000, 4'd0,  5'd1,  1'b1, '{ST_OK, 4'd2, 1'b0, 64'd0}},
        '{OP_SCHED,   64'haaaa_aaaa_aaaa_aaaa, 4'd5,  5'd1,  1'b0, NO_WANT},
        '{OP_CREATE,  64'h0000_0000_0000_1000, 4'd0,  5'd13, 1'b0, NO_WANT},
        '{OP_CREATE,  64'hdead_beef_dead_beef, 4'd3,  5'd1,  1'b1, '{ST_FULL, 4'd0, 1'b0, 64'd0}},
        '{OP_DESTROY, 64'h0000_0000_0000_0000, 4'd15, 5'd1,  1'b1, '{ST_OK, 4'd15, 1'b0, 64'd0}},
        '{OP_SCHED,   64'h5555_5555_5555_5555, 4'd0,  5'd1,  1'b0, NO_WANT},
        '{OP_DESTROY, 64'hffff_ffff_ffff_ffff, 4'd2,  5'd1,  1'b1, '{ST_OK, 4'd2, 1'b0, 64'd0}},
        '{OP_SPARE,   64'hffff_ffff_ffff_ffff, 4'd7,  5'd1,  1'b1, '{ST_OK, 4'd0, 1'b0, 64'd0}},
        '{OP_SCHED,   64'h8000_0000_0000_0001, 4'd9,  5'd1,  1'b0, NO_WANT},
        '{OP_CREATE,  64'hcafe_f00d_1234_5678, 4'd0,  5'd1,  1'b1, '{ST_OK, 4'd2, 1'b0, 64'd0}},
        '{OP_SCHED,   64'h7fff_ffff_ffff_fffe, 4'd0,  5'd1,  1'b0, NO_WANT}
    };

    aging_priority_task_scheduler_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_address_in     (s_address_in),
        .s_target_slot    (s_target_slot),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot_out       (m_slot_out),
        .m_switched       (m_switched),
        .m_resume_address (m_resume_address)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Table contents right after reset: slot 0 alone is live and running.
    function automatic void clear_table();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_prio[i] = PRIO_FREE;
            slot_saved_pc[i] = '0;
        end
        slot_live[0] = 1'b1;
        slot_prio[0] = '0;
        cur_slot = '0;
    endfunction

    // Applies one operation to the shadow table and returns the result it owes.
    function automatic sched_result_t step_scheduler(logic [OP_W-1:0] op,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [TGT_W-1:0] tgt);
        sched_result_t r;
        int i;
        int best;
        int unsigned sum;
        logic found;
        logic [PRIO_W-1:0] best_prio;
        r = '0;
        found = 1'b0;
        best = 0;
        best_prio = '0;
        case (op)
            OP_CREATE: begin
                r.status = ST_FULL;
                for (i = 0; i < SLOTS; i++) begin
                    if (!found && !slot_live[i]) begin
                        found = 1'b1;
                        slot_live[i] = 1'b1;
                        slot_prio[i] = '0;
                        slot_saved_pc[i] = addr;
                        r.status = ST_OK;
                        r.slot = SOUT_W'(i);
                    end
                end
            end
            OP_DESTROY: begin
                if (int'(tgt) < SLOTS) begin
                    slot_live[tgt] = 1'b0;
                    slot_prio[tgt] = PRIO_FREE;
                end
                r.slot = tgt;
            end
            OP_SCHED: begin
                // The running slot ages and saves its resume point, live or not.
                sum = int'(slot_prio[cur_slot]) + int'(PRIO_RUN_ADD);
                slot_prio[cur_slot] = (sum > int'(PRIO_MAX)) ? PRIO_MAX : PRIO_W'(sum);
                slot_saved_pc[cur_slot] = addr;
                // Every live slot drifts down, then the lowest wins, lowest index first.
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_live[i]) begin
                        if (slot_prio[i] != '0)
                            slot_prio[i] = slot_prio[i] - 1'b1;
                        if (!found || slot_prio[i] < best_prio) begin
                            found = 1'b1;
                            best = i;
                            best_prio = slot_prio[i];
                        end
                    end
                end
                if (!found) begin
                    r.status = ST_NO_TASK;
                end else if (SLOT_W'(best) != cur_slot) begin
                    cur_slot = SLOT_W'(best);
                    r.slot = SOUT_W'(best);
                    r.switched = 1'b1;
                    r.resume = slot_saved_pc[best];
                end else begin
                    r.slot = SOUT_W'(best);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0h, wanted %0h", $time, what, got, want);
    endtask

    // Offers one input transfer, with random idle cycles ahead of it, and books
    // its result once the transfer happens.
    task automatic push_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [TGT_W-1:0] tgt, input logic chk,
                             input sched_result_t want);
        sched_result_t owed;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_address_in <= addr;
        s_target_slot <= tgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        owed = step_scheduler(op, addr, tgt);
        outcomes_due.push_back(chk ? want : owed);
    endtask

    // The receiver stalls at random at the current rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Each result transfer is compared with the oldest booked result.
    always @(posedge aclk) begin : result_check
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_switched) switches_seen++;
            if (m_status == ST_FULL) full_seen++;
            if (m_status == ST_NO_TASK) empty_ticks_seen++;
            if (outcomes_due.size() == 0) begin
                flag_mismatch("result with nothing pending, status", m_status, '0);
            end else begin
                want = outcomes_due.pop_front();
                if (m_status !== want.status)
                    flag_mismatch("status", m_status, want.status);
                if (m_slot_out !== want.slot)
                    flag_mismatch("slot_out", m_slot_out, want.slot);
                if (m_switched !== want.switched)
                    flag_mismatch("switched", m_switched, want.switched);
                if (m_resume_address !== want.resume)
                    flag_mismatch("resume_address", m_resume_address, want.resume);
            end
        end
    end

    initial begin : stimulus
        int k;
        int n;
        int counted;
        int mood;
        int pick;
        int cut_sched;
        int cut_create;
        int cut_destroy;
        int drain_cycles;
        logic [OP_W-1:0] op;
        logic [ADDR_W-1:0] addr;
        logic [TGT_W-1:0] tgt;
        int live_list [$];

        clear_table();
        src_idle_pct = 10;
        sink_stall_pct = 64;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed plan first.
        for (k = 0; k < $size(plan); k++) begin
            for (n = 0; n < plan[k].reps; n++)
                push_item(plan[k].op, plan[k].addr, plan[k].tgt, plan[k].chk, plan[k].want);
        end

        // Random traffic in blocks that lean toward filling, draining or mixing.
        counted = 0;
        mood = 0;
        cut_sched = 40;
        cut_create = 65;
        cut_destroy = 95;
        while (counted < RANDOM_ITEMS) begin
            if (counted == RANDOM_ITEMS / 3) begin
                src_idle_pct = 64;
                sink_stall_pct = 10;
            end else if (counted == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            if (counted % 40 == 0) begin
                mood = $urandom_range(0, 2);
                case (mood)
                    0: begin cut_sched = 40; cut_create = 65; cut_destroy = 95; end
                    1: begin cut_sched = 25; cut_create = 80; cut_destroy = 95; end
                    default: begin cut_sched = 35; cut_create = 42; cut_destroy = 97; end
                endcase
            end

            pick = $urandom_range(0, 99);
            if (pick < cut_sched) op = OP_SCHED;
            else if (pick < cut_create) op = OP_CREATE;
            else if (pick < cut_destroy) op = OP_DESTROY;
            else op = OP_SPARE;

            case ($urandom_range(0, 9))
                0: addr = '0;
                1: addr = '1;
                default: addr = {$urandom, $urandom};
            endcase

            // Destroys mostly hit live slots so the table really empties.
            tgt = TGT_W'($urandom_range(0, 15));
            if (op == OP_DESTROY && $urandom_range(0, 9) < 7) begin
                live_list.delete();
                for (k = 0; k < SLOTS; k++)
                    if (slot_live[k]) live_list.push_back(k);
                if (live_list.size() > 0)
                    tgt = TGT_W'(live_list[$urandom_range(0, live_list.size() - 1)]);
            end

            push_item(op, addr, tgt, 1'b0, NO_WANT);
            if (op != OP_SPARE) counted++;
        end
        s_valid <= 1'b0;

        // Let the last results drain, then a little more for stray transfers.
        drain_cycles = 0;
        while (outcomes_due.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (outcomes_due.size() != 0) begin
            $display("Timed out with %0d results still owed", outcomes_due.size());
            $display("*** FAILED ***");
        end else begin
            repeat (60) @(posedge aclk);
            $display("Checked %0d results: %0d context switches, %0d full-table creates,",
                     results_seen, switches_seen, full_seen);
            $display("%0d ticks with no live task, over three flow-control mixes; %0d mismatches.",
                     empty_ticks_seen, mismatches);
            if (mismatches == 0 && outcomes_due.size() == 0) begin
                $display("*** PASSED ***");
            end else begin
                $display("*** FAILED ***");
            end
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #5ms;
        $display("Watchdog expired before the run completed");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* aging_priority_task_scheduler_unit.f */
hw/rtl/apts_pkg.sv
hw/rtl/apts_cell.sv
hw/rtl/aging_priority_task_scheduler_unit.sv
tb/tb_aging_priority_task_scheduler_unit.sv
